/* sv/assert_macros.svh */
// shared assertion macros for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition implies consequence in the same cycle
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// condition implies consequence in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* sv/wve_pkg.sv */
package wve_pkg;

    localparam int ALPHA_W      = 9;
    localparam int ANGLE_W      = 9;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 9'd256;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 9'd38;
    localparam logic [ANGLE_W-1:0] DEG_PER_TURN = 9'd360;

    // item kinds
    localparam logic MODE_EDGE = 1'b0;
    localparam logic MODE_READ = 1'b1;

    // shared unit operations
    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2
    } t_op;

endpackage

/* sv/wve_ifs.sv */
interface wve_in_if;
    import wve_pkg::*;
    logic valid;
    logic ready;
    logic mode;
    logic b_level;
    modport source (output valid, output mode, output b_level, input ready);
    modport sink (input valid, input mode, input b_level, output ready);
endinterface

interface wve_out_if;
    import wve_pkg::*;
    logic               valid;
    logic               ready;
    logic               updated;
    logic [ANGLE_W-1:0] angle_deg;
    modport source (output valid, output updated, output angle_deg, input ready);
    modport sink (input valid, input updated, input angle_deg, output ready);
endinterface

interface wve_cfg_if;
    import wve_pkg::*;
    logic               valid;
    logic               ready;
    logic [ALPHA_W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* sv/wve_unit.sv */
module wve_unit #(
    parameter int W  = 27,
    parameter int MA = 8,
    parameter int MB = 18
) (
    input  wve_pkg::t_op          i_op,
    input  logic signed [W-1:0]   i_a,
    input  logic signed [W-1:0]   i_b,
    output logic signed [W-1:0]   o_res
);
    import wve_pkg::*;

    logic [MA+MB-1:0] prod;

    // unsigned product of the low operand bits
    assign prod = i_a[MA-1:0] * i_b[MB-1:0];

    always_comb begin
        unique case (i_op)
            OP_ADD:  o_res = i_a + i_b;
            OP_SUB:  o_res = i_a - i_b;
            OP_MUL:  o_res = $signed({{(W-MA-MB){1'b0}}, prod});
            default: o_res = i_a;
        endcase
    end

endmodule

/* sv/wind_vane_encoder_filter.sv */
// wind vane encoder filter: an edge word (mode 0) steps the raw position up when b_level
// is high and down when low, modulo COUNTS_PER_TURN, and gives no result; the next word
// can follow it straight away. a read word (mode 1) always gives one result word. with
// no edge since the last read it reports updated=0, angle 0: the read goes straight to
// the result register load, and the input is ready again once the result is loaded.
// otherwise the circular exponential filter runs on one shared adder/multiplier under a
// small sequencer: difference, wrap, magnitude, alpha multiply, add, wrap, then one
// multiply by a fixed-point degree scale that turns the whole position into degrees, then
// the result register load. the next word is taken once the seven sequencer steps and
// the load step are through. the input is not ready while a read is being processed, and
// a read also waits while the previous result word is still held in the output register.
// edge words are still taken while a result waits. alpha is Q1.8 (reset 38), values
// above 256 act as 256; write it only when idle.
`include "assert_macros.svh"

module wind_vane_encoder_filter #(
    parameter int COUNTS_PER_TURN = 256,
    parameter int FRAC_BITS       = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    wve_in_if.sink    i_in,
    wve_out_if.source o_out,
    wve_cfg_if.sink   i_cfg
);
    import wve_pkg::*;

    // position width, filtered width, multiplier b width, shared datapath width
    localparam int CW = $clog2(COUNTS_PER_TURN);
    localparam int FW = CW + FRAC_BITS;
    localparam int MW = CW + 10;
    localparam int AW = (FRAC_BITS > CW + 9) ? (CW + FRAC_BITS + 2) : (2 * CW + 11);
    localparam int SW = AW + FRAC_BITS;
    localparam int DEG_SHIFT = 2 * CW;

    localparam logic [CW-1:0]        POS_MAX  = CW'(COUNTS_PER_TURN - 1);
    localparam logic signed [AW-1:0] N_TURN   = AW'(COUNTS_PER_TURN);
    localparam logic signed [AW-1:0] HALF     = AW'(COUNTS_PER_TURN / 2);
    localparam logic signed [AW-1:0] NEG_HALF = -HALF;
    localparam logic signed [AW-1:0] SPAN     = N_TURN <<< FRAC_BITS;

    // degree scale: ceil(360 * 2^(2*cw) / counts), exact floor for every whole position
    localparam longint DEG_NUM = longint'(DEG_PER_TURN) << DEG_SHIFT;
    localparam logic [MW-1:0] DEG_SCALE =
        MW'((DEG_NUM + longint'(COUNTS_PER_TURN) - 1) / longint'(COUNTS_PER_TURN));

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_DIFF  = 9'b000000010,
        S_WRAP  = 9'b000000100,
        S_ABS   = 9'b000001000,
        S_MULA  = 9'b000010000,
        S_STEP  = 9'b000100000,
        S_WRAPF = 9'b001000000,
        S_MULD  = 9'b010000000,
        S_PUT   = 9'b100000000
    } t_state;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_pos;
    logic [FW-1:0]       r_fp;
    logic                r_changed;
    logic [ALPHA_W-1:0]  r_alpha;
    logic signed [AW-1:0] r_acc;
    logic                r_neg;
    logic                r_upd;       // result kind waiting for the output register
    logic                r_ov;
    logic                r_out_upd;
    logic [ANGLE_W-1:0]  r_out_angle;

    t_op                 u_op;
    logic signed [AW-1:0] u_a, u_b, u_res;
    logic [ALPHA_W-1:0]  alpha_sat;
    logic [SW-1:0]       step_full;
    logic                in_acc, out_free;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == S_IDLE);
    assign in_acc      = i_in.valid && i_in.ready;
    assign out_free    = !r_ov || o_out.ready;

    assign o_out.valid     = r_ov;
    assign o_out.updated   = r_out_upd;
    assign o_out.angle_deg = r_out_angle;

    // alpha above one turns into full tracking
    assign alpha_sat = (r_alpha > ALPHA_ONE) ? ALPHA_ONE : r_alpha;

    // step magnitude: (alpha * mag) << frac >> 8, truncated
    assign step_full = {r_acc, {FRAC_BITS{1'b0}}} >> 8;

    wve_unit #(
        .W  (AW),
        .MA (CW),
        .MB (MW)
    ) u_unit (
        .i_op  (u_op),
        .i_a   (u_a),
        .i_b   (u_b),
        .o_res (u_res)
    );

    // operand selection per sequencer step
    always_comb begin
        u_op = OP_ADD;
        u_a  = r_acc;
        u_b  = '0;
        unique case (r_state)
            S_DIFF: begin
                u_op = OP_SUB;
                u_a  = $signed({{(AW-CW){1'b0}}, r_pos});
                u_b  = $signed({{(AW-CW){1'b0}}, r_fp[FW-1:FRAC_BITS]});
            end
            S_WRAP: begin
                priority if (r_acc > HALF) begin
                    u_op = OP_SUB;
                    u_b  = N_TURN;
                end else if (r_acc < NEG_HALF) begin
                    u_b  = N_TURN;
                end else begin
                    u_b  = '0;
                end
            end
            S_ABS: begin
                if (r_acc[AW-1]) begin
                    u_op = OP_SUB;
                    u_a  = '0;
                    u_b  = r_acc;
                end
            end
            S_MULA: begin
                u_op = OP_MUL;
                u_b  = $signed({{(AW-ALPHA_W){1'b0}}, alpha_sat});
            end
            S_STEP: begin
                u_op = r_neg ? OP_SUB : OP_ADD;
                u_a  = $signed({{(AW-FW){1'b0}}, r_fp});
                u_b  = $signed(step_full[AW-1:0]);
            end
            S_WRAPF: begin
                priority if (r_acc >= SPAN) begin
                    u_op = OP_SUB;
                    u_b  = SPAN;
                end else if (r_acc[AW-1]) begin
                    u_b  = SPAN;
                end else begin
                    u_b  = '0;
                end
            end
            S_MULD: begin
                // whole position times the degree scale, degrees sit above bit 2*cw
                u_op = OP_MUL;
                u_a  = $signed({{(AW-CW){1'b0}}, r_fp[FW-1:FRAC_BITS]});
                u_b  = $signed({{(AW-MW){1'b0}}, DEG_SCALE});
            end
            S_IDLE, S_PUT: begin
                u_op = OP_ADD;
            end
            default: begin
                u_op = OP_ADD;
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && i_in.mode == MODE_READ) begin
                    n_state = r_changed ? S_DIFF : S_PUT;
                end
            end
            S_DIFF:  n_state = S_WRAP;
            S_WRAP:  n_state = S_ABS;
            S_ABS:   n_state = S_MULA;
            S_MULA:  n_state = S_STEP;
            S_STEP:  n_state = S_WRAPF;
            S_WRAPF: n_state = S_MULD;
            S_MULD:  n_state = S_PUT;
            S_PUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pos     <= '0;
            r_fp      <= '0;
            r_changed <= 1'b0;
            r_alpha   <= ALPHA_RESET;
            r_ov      <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg.valid && i_cfg.ready) begin
                r_alpha <= i_cfg.data;
            end

            // edge word: step the raw counter round the turn
            if (in_acc && i_in.mode == MODE_EDGE) begin
                r_changed <= 1'b1;
                if (i_in.b_level) begin
                    r_pos <= (r_pos == POS_MAX) ? '0 : r_pos + 1'b1;
                end else begin
                    r_pos <= (r_pos == '0) ? POS_MAX : r_pos - 1'b1;
                end
            end

            if (r_state == S_WRAPF) begin
                r_fp      <= u_res[FW-1:0];
                r_changed <= 1'b0;
            end

            // a new word loads over a drained one in the same cycle
            if (r_state == S_PUT && out_free) begin
                r_ov <= 1'b1;
            end else if (r_ov && o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_upd <= r_changed;
            end
            S_DIFF, S_WRAP, S_MULA, S_STEP, S_WRAPF, S_MULD: begin
                r_acc <= u_res;
            end
            S_ABS: begin
                r_neg <= r_acc[AW-1];
                r_acc <= u_res;
            end
            S_PUT: begin
                if (out_free) begin
                    r_out_upd   <= r_upd;
                    r_out_angle <= r_upd ? r_acc[DEG_SHIFT +: ANGLE_W] : '0;
                end
            end
            default: begin
                r_acc <= r_acc;
            end
        endcase
    end

    // a read with nothing changed goes straight to the result register
    `ASSERT_NEXT(a_quiet_read, i_clk, i_rst_n,
        in_acc && i_in.mode == MODE_READ && !r_changed, r_state == S_PUT && !r_upd)
    // a stale result carries angle zero
    `ASSERT_SAME(a_stale_zero, i_clk, i_rst_n,
        o_out.valid && !o_out.updated, o_out.angle_deg == '0)
    // reported angle stays within one turn
    `ASSERT_SAME(a_angle_range, i_clk, i_rst_n, o_out.valid, o_out.angle_deg < 9'd360)
    // filtered position stays inside one turn
    `ASSERT_SAME(a_fp_range, i_clk, i_rst_n, 1'b1,
        $signed({{(AW-FW){1'b0}}, r_fp}) < SPAN)
    // the changed flag is clear once the filtered position is written
    `ASSERT_NEXT(a_flag_clear, i_clk, i_rst_n, r_state == S_WRAPF, !r_changed)

endmodule
